[src/pse_pkg.sv]
// Shared constants, types and codes of the point set with extents.
`default_nettype none

package pse_pkg;

  // Number of point slots.
  localparam int unsigned CAPACITY = 64;
  // Coordinates are taken in their low COORD_BITS bits (at most FIELD_W).
  localparam int unsigned COORD_BITS = 16;
  // Width of the coordinate fields on the input beat.
  localparam int unsigned FIELD_W = 16;
  // Width of the extent fields on the output beat.
  localparam int unsigned EXT_W = 16;

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  localparam int unsigned IN_TDATA_W = ((2 * FIELD_W + 7) / 8) * 8;
  localparam int unsigned IN_PAD_W = IN_TDATA_W - 2 * FIELD_W;
  localparam int unsigned OUT_TDATA_W = ((CNT_W + 2 * EXT_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W = OUT_TDATA_W - CNT_W - 2 * EXT_W;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_QUERY  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_NO_MATCH = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_DRAIN  = 2'd2,
    S_COMMIT = 2'd3
  } state_e;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
    logic out_free;
  } dp_sts_t;

  // Internal state made visible for the checks at the top level.
  typedef struct packed {
    logic [CAPACITY-1:0] valid;
    cnt_t                count;
  } dp_obs_t;

endpackage : pse_pkg

`default_nettype wire

[src/pse_ctrl.sv]
// Controller state machine that sequences the slot scan and the commit of each item.
`default_nettype none

module pse_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output pse_pkg::ctrl_cmd_t      cmd_o,
  input  wire pse_pkg::dp_sts_t   sts_i
);
  import pse_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.scan_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.start  = in_valid_i;
      end
      S_SCAN: begin
        cmd_o.scan   = 1'b1;
      end
      S_DRAIN: begin
        cmd_o        = '0;
      end
      S_COMMIT: begin
        cmd_o.commit = sts_i.out_free;
      end
      default: begin
        cmd_o        = '0;
      end
    endcase
  end

endmodule : pse_ctrl

`default_nettype wire

[src/pse_dpath.sv]
// Datapath: coordinate memory, valid bits, scan counter, extent accumulators, output register.
`default_nettype none

module pse_dpath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire pse_pkg::ctrl_cmd_t            cmd_i,
  output pse_pkg::dp_sts_t                   sts_o,
  output pse_pkg::dp_obs_t                   obs_o,
  input  wire logic [1:0]                    action_i,
  input  wire logic [pse_pkg::FIELD_W-1:0]   x_coord_i,
  input  wire logic [pse_pkg::FIELD_W-1:0]   y_coord_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [1:0]                         status_o,
  output logic [pse_pkg::CNT_W-1:0]          point_count_o,
  output logic [pse_pkg::EXT_W-1:0]          extent_height_o,
  output logic [pse_pkg::EXT_W-1:0]          extent_width_o
);
  import pse_pkg::*;

  // Coordinate memory: one write port at commit, one registered read port for the scan.
  coord_t x_mem [CAPACITY];
  coord_t y_mem [CAPACITY];

  logic [CAPACITY-1:0] valid_q, valid_d;
  cnt_t                count_q, count_d;

  logic [1:0] act_q;
  coord_t     x_q, y_q;
  idx_t       cnt_q;

  logic   proc_q;
  logic   rd_v_q;
  idx_t   rd_idx_q;
  coord_t rd_x_q, rd_y_q;

  logic   hit_q, free_q;
  idx_t   hit_idx_q, free_idx_q;
  coord_t xmin_q, xmax_q, ymin_q, ymax_q;

  logic    out_vld_q;
  status_e out_status_q;
  cnt_t    out_count_q;
  logic [EXT_W-1:0] out_h_q, out_w_q;

  logic is_ins, is_rem, modify, match, place;
  idx_t slot;
  coord_t fxmin, fxmax, fymin, fymax;
  logic [COORD_BITS:0] dx, dy;
  status_e status_d;

  assign is_ins = (act_q == ACT_INSERT);
  assign is_rem = (act_q == ACT_REMOVE);
  assign modify = is_ins || is_rem;

  // The set holds each point at most once, so a match is the only copy.
  assign match = rd_v_q && modify && (rd_x_q == x_q) && (rd_y_q == y_q);

  // Scan counter and item capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      act_q <= action_i;
      x_q   <= coord_t'(x_coord_i[COORD_BITS-1:0]);
      y_q   <= coord_t'(y_coord_i[COORD_BITS-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      proc_q <= 1'b0;
      rd_v_q <= 1'b0;
    end else begin
      proc_q <= cmd_i.scan;
      rd_v_q <= valid_q[cnt_q];
      if (cmd_i.start) begin
        cnt_q <= '0;
      end else if (cmd_i.scan) begin
        cnt_q <= cnt_q + idx_t'(1);
      end
    end
  end

  assign sts_o.scan_last = (cnt_q == idx_t'(CAPACITY - 1));
  assign sts_o.out_free  = !out_vld_q || out_ready_i;

  // Memory read and write.
  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q;
    if (cmd_i.scan) begin
      rd_x_q <= x_mem[cnt_q];
      rd_y_q <= y_mem[cnt_q];
    end
    if (cmd_i.commit && place) begin
      x_mem[slot] <= x_q;
      y_mem[slot] <= y_q;
    end
  end

  // Match, free slot and extent accumulation over the scanned slots.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      hit_idx_q  <= '0;
      free_idx_q <= '0;
      xmin_q     <= '0;
      xmax_q     <= '0;
      ymin_q     <= '0;
      ymax_q     <= '0;
    end else if (cmd_i.start) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
      xmin_q <= '0;
      xmax_q <= '0;
      ymin_q <= '0;
      ymax_q <= '0;
    end else if (proc_q) begin
      if (match && !hit_q) begin
        hit_q     <= 1'b1;
        hit_idx_q <= rd_idx_q;
      end
      if (!rd_v_q && !free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= rd_idx_q;
      end
      // A point that this item removes is left out; an insert adds it back at commit.
      if (rd_v_q && !match) begin
        if (rd_x_q < xmin_q) xmin_q <= rd_x_q;
        if (rd_x_q > xmax_q) xmax_q <= rd_x_q;
        if (rd_y_q < ymin_q) ymin_q <= rd_y_q;
        if (rd_y_q > ymax_q) ymax_q <= rd_y_q;
      end
    end
  end

  // Commit: the lowest free slot after the old copy is cleared.
  always_comb begin
    place = is_ins && (free_q || hit_q);
    if (free_q && (!hit_q || (free_idx_q < hit_idx_q))) begin
      slot = free_idx_q;
    end else begin
      slot = hit_idx_q;
    end

    fxmin = (place && (x_q < xmin_q)) ? x_q : xmin_q;
    fxmax = (place && (x_q > xmax_q)) ? x_q : xmax_q;
    fymin = (place && (y_q < ymin_q)) ? y_q : ymin_q;
    fymax = (place && (y_q > ymax_q)) ? y_q : ymax_q;
    dx = (COORD_BITS + 1)'(fxmax) - (COORD_BITS + 1)'(fxmin);
    dy = (COORD_BITS + 1)'(fymax) - (COORD_BITS + 1)'(fymin);

    count_d = count_q - cnt_t'(modify && hit_q) + cnt_t'(place);

    if (is_ins && !place) begin
      status_d = ST_FULL;
    end else if (is_rem && !hit_q) begin
      status_d = ST_NO_MATCH;
    end else begin
      status_d = ST_DONE;
    end

    valid_d = valid_q;
    if (modify && hit_q) valid_d[hit_idx_q] = 1'b0;
    if (place) valid_d[slot] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
    end else if (cmd_i.commit) begin
      valid_q <= valid_d;
      count_q <= count_d;
    end
  end

  // Output register: holds a finished result until the beat is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_status_q <= status_d;
      out_count_q  <= count_d;
      out_h_q      <= dy[EXT_W-1:0];
      out_w_q      <= dx[EXT_W-1:0];
    end
  end

  assign out_valid_o     = out_vld_q;
  assign status_o        = out_status_q;
  assign point_count_o   = out_count_q;
  assign extent_height_o = out_h_q;
  assign extent_width_o  = out_w_q;

  assign obs_o.valid = valid_q;
  assign obs_o.count = count_q;

endmodule : pse_dpath

`default_nettype wire

[src/point_set_with_extents_top.sv]
// Top level of the point set with extents: controller, datapath and checks.
//
// Channel  Dir  Beat contents
// s_axis   in   tdata: x_coord, y_coord; tuser: action
// m_axis   out  tdata: point_count, extent_height, extent_width; tuser: status
//
// One item at a time. After a beat is accepted the datapath reads every slot of the
// coordinate memory, one per cycle, before the result is committed; the next beat is
// taken only after that commit. A result waits in an output register; a stall on
// m_axis holds only the commit of the following item. Reset empties the set.
`default_nettype none

module point_set_with_extents_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata, lowest bit up: x_coord[15:0], y_coord[31:16]
  input  wire logic [pse_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // tuser: action[1:0]
  input  wire logic [1:0]                        s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // tdata, lowest bit up: point_count[6:0], extent_height[22:7], extent_width[38:23], zero
  output logic [pse_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
  // tuser: status[1:0]
  output logic [1:0]                             m_axis_tuser
);
  import pse_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;
  dp_obs_t   obs;
  cnt_t             point_count;
  logic [EXT_W-1:0] extent_height, extent_width;

  pse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  pse_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .obs_o           (obs),
    .action_i        (s_axis_tuser),
    .x_coord_i       (s_axis_tdata[FIELD_W-1:0]),
    .y_coord_i       (s_axis_tdata[2*FIELD_W-1:FIELD_W]),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .status_o        (m_axis_tuser),
    .point_count_o   (point_count),
    .extent_height_o (extent_height),
    .extent_width_o  (extent_width)
  );

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, extent_width, extent_height, point_count};

  // The count always agrees with the number of occupied slots.
  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(obs.valid) == int'(obs.count))
    else $error("point count differs from occupied slots");

  // A dropped insert is reported only when every slot is taken.
  a_full_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == ST_FULL)) |-> (int'(point_count) == CAPACITY))
    else $error("store-full status with free slots");

  // An accepted beat keeps the input closed while it is worked on.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted during a scan");

  // A result never reports more points than there are slots.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (int'(point_count) <= CAPACITY))
    else $error("point count above capacity");

endmodule : point_set_with_extents_top

`default_nettype wire
